// ===== sv/lob_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_pkg
// Shared types and constants for the limit order book matcher.
// ----------------------------------------------------------------------------
package lob_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int TRD_W    = 6;
  localparam logic [TRD_W-1:0] MAX_TRADES = 6'd63;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_NOCROSS = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic SIDE_BUY   = 1'b0;
  localparam logic ITEM_TRADE = 1'b0;
  localparam logic ITEM_STAT  = 1'b1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        order_id;
    logic               side;
    logic               order_kind;
    logic signed [31:0] limit_price;
    logic [31:0]        amount;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        id;
    logic signed [31:0] price;
    logic [31:0]        remaining;
    logic               side;
    logic               kind;
    logic [31:0]        arrival;
  } slot_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    slot_t            data;
  } best_t;

  typedef struct packed {
    logic               item_kind;
    logic [31:0]        buyer_id;
    logic [31:0]        seller_id;
    logic signed [31:0] buyer_price;
    logic signed [31:0] seller_price;
    logic [31:0]        filled;
    logic [2:0]         status;
    logic [CNT_W-1:0]   resting_orders;
    logic               last;
  } out_item_t;

endpackage

// ===== sv/lob_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_in_if / lob_out_if
// Valid/ready channels for order requests and result items.
// ----------------------------------------------------------------------------
interface lob_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [31:0]        order_id;
  logic               side;
  logic               order_kind;
  logic signed [31:0] limit_price;
  logic [31:0]        amount;

  modport source (output valid, opcode, order_id, side, order_kind, limit_price, amount,
                  input ready);
  modport sink (input valid, opcode, order_id, side, order_kind, limit_price, amount,
                output ready);
endinterface

interface lob_out_if;
  logic                         valid;
  logic                         ready;
  logic                         item_kind;
  logic [31:0]                  buyer_id;
  logic [31:0]                  seller_id;
  logic signed [31:0]           buyer_price;
  logic signed [31:0]           seller_price;
  logic [31:0]                  filled;
  logic [2:0]                   status;
  logic [lob_pkg::CNT_W-1:0]    resting_orders;
  logic                         last;

  modport source (output valid, item_kind, buyer_id, seller_id, buyer_price, seller_price,
                  filled, status, resting_orders, last, input ready);
  modport sink (input valid, item_kind, buyer_id, seller_id, buyer_price, seller_price,
                filled, status, resting_orders, last, output ready);
endinterface

// ===== sv/lob_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_front
// Accepts requests into a two-entry queue ahead of the matching engine.
// ----------------------------------------------------------------------------
module lob_front (
  input  logic              clk,
  input  logic              rst_n,
  lob_in_if.sink            in_ch,
  output logic              q_valid,
  output lob_pkg::in_item_t q_item,
  input  logic              q_pop
);

  lob_pkg::in_item_t fifo_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;
  logic              push;
  logic              pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign pop         = q_pop && q_valid;
  assign q_item      = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= '{opcode: in_ch.opcode, order_id: in_ch.order_id,
                            side: in_ch.side, order_kind: in_ch.order_kind,
                            limit_price: in_ch.limit_price, amount: in_ch.amount};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/lob_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_back
// Order store and matching sequencer: scans the store one slot a cycle,
// applies adds, cancels and modifies, and emits trades and status.
// ----------------------------------------------------------------------------
module lob_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  lob_pkg::in_item_t q_item,
  output logic              q_pop,
  lob_out_if.source         out_ch
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_MDEC = 4'd3;
  localparam logic [3:0] S_TRD  = 4'd4;
  localparam logic [3:0] S_UPDB = 4'd5;
  localparam logic [3:0] S_UPDS = 4'd6;
  localparam logic [3:0] S_FAK  = 4'd7;
  localparam logic [3:0] S_STAT = 4'd8;

  localparam logic [lob_pkg::CNT_W-1:0] SCAN_END = lob_pkg::CNT_W'(lob_pkg::CAPACITY);
  localparam logic [lob_pkg::CNT_W-1:0] CNT_ONE  = lob_pkg::CNT_W'(1);
  localparam logic [lob_pkg::TRD_W-1:0] TRD_ONE  = lob_pkg::TRD_W'(1);

  lob_pkg::slot_t                mem_r [lob_pkg::CAPACITY];
  logic [lob_pkg::CAPACITY-1:0]  valid_r;

  logic [3:0]                    state_r;
  lob_pkg::in_item_t             cur_r;
  logic                          mode_r;
  logic [lob_pkg::CNT_W-1:0]     scan_cnt_r;
  logic                          rd_live_r;
  logic [lob_pkg::IDX_W-1:0]     rd_idx_r;
  lob_pkg::slot_t                rd_data_r;
  logic                          rd_valid_r;

  logic                          match_found_r;
  logic [lob_pkg::IDX_W-1:0]     match_idx_r;
  logic                          match_kind_r;
  logic                          free_found_r;
  logic [lob_pkg::IDX_W-1:0]     free_idx_r;
  lob_pkg::best_t                buy_r;
  lob_pkg::best_t                sell_r;

  logic [31:0]                   arrival_r;
  logic [lob_pkg::CNT_W-1:0]     count_r;
  logic [lob_pkg::TRD_W-1:0]     trades_r;
  logic [lob_pkg::IDX_W-1:0]     new_idx_r;
  logic [2:0]                    status_r;
  logic [31:0]                   qty_r;

  logic                          out_valid_r;
  lob_pkg::out_item_t            out_r;

  logic [31:0]                   age;
  logic [31:0]                   buy_age;
  logic [31:0]                   sell_age;
  logic                          buy_better;
  logic                          sell_better;
  logic                          scanning;
  logic                          cross_ok;
  logic                          add_ok;
  logic [2:0]                    add_status;
  logic                          out_free;
  logic                          out_load;
  logic                          mem_we;
  logic [lob_pkg::IDX_W-1:0]     mem_wa;
  lob_pkg::slot_t                mem_wd;
  logic [31:0]                   buy_left;
  logic [31:0]                   sell_left;

  assign scanning = (state_r == S_SCAN) && (scan_cnt_r != SCAN_END);
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = ((state_r == S_TRD) || (state_r == S_STAT)) && out_free;
  assign q_pop    = (state_r == S_IDLE);

  // Priority compare of the slot just read against the best so far
  always_comb begin
    age         = arrival_r - rd_data_r.arrival;
    buy_age     = arrival_r - buy_r.data.arrival;
    sell_age    = arrival_r - sell_r.data.arrival;
    buy_better  = !buy_r.found || (rd_data_r.price > buy_r.data.price) ||
                  ((rd_data_r.price == buy_r.data.price) && (age > buy_age));
    sell_better = !sell_r.found || (rd_data_r.price < sell_r.data.price) ||
                  ((rd_data_r.price == sell_r.data.price) && (age > sell_age));
  end

  // Admission checks of an add, in priority order
  always_comb begin
    if (cur_r.side == lob_pkg::SIDE_BUY) begin
      cross_ok = sell_r.found && (cur_r.limit_price >= sell_r.data.price);
    end else begin
      cross_ok = buy_r.found && (cur_r.limit_price <= buy_r.data.price);
    end
    add_ok = 1'b0;
    if (match_found_r) begin
      add_status = lob_pkg::ST_DUP;
    end else if (cur_r.amount == 32'd0) begin
      add_status = lob_pkg::ST_FULL;
    end else if (cur_r.order_kind && !cross_ok) begin
      add_status = lob_pkg::ST_NOCROSS;
    end else if (!free_found_r) begin
      add_status = lob_pkg::ST_FULL;
    end else begin
      add_status = lob_pkg::ST_DONE;
      add_ok     = 1'b1;
    end
  end

  assign buy_left  = buy_r.data.remaining - qty_r;
  assign sell_left = sell_r.data.remaining - qty_r;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = free_idx_r;
    mem_wd = '{id: cur_r.order_id, price: cur_r.limit_price, remaining: cur_r.amount,
               side: cur_r.side, kind: cur_r.order_kind, arrival: arrival_r};
    case (state_r)
      S_DEC: begin
        mem_we = (cur_r.opcode == lob_pkg::OP_ADD) && add_ok;
      end
      S_UPDB: begin
        mem_we           = 1'b1;
        mem_wa           = buy_r.idx;
        mem_wd           = buy_r.data;
        mem_wd.remaining = buy_left;
      end
      S_UPDS: begin
        mem_we           = 1'b1;
        mem_wa           = sell_r.idx;
        mem_wd           = sell_r.data;
        mem_wd.remaining = sell_left;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_wa] <= mem_wd;
    rd_data_r <= mem_r[scan_cnt_r[lob_pkg::IDX_W-1:0]];
    rd_valid_r <= valid_r[scan_cnt_r[lob_pkg::IDX_W-1:0]];
    rd_idx_r   <= scan_cnt_r[lob_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      valid_r       <= '0;
      arrival_r     <= '0;
      count_r       <= '0;
      rd_live_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      mode_r        <= 1'b0;
      scan_cnt_r    <= '0;
      trades_r      <= '0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      buy_r.found   <= 1'b0;
      sell_r.found  <= 1'b0;
    end else begin
      rd_live_r <= scanning;
      if (out_valid_r && out_ch.ready && !out_load) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r         <= q_item;
            trades_r      <= '0;
            mode_r        <= 1'b0;
            scan_cnt_r    <= '0;
            match_found_r <= 1'b0;
            free_found_r  <= 1'b0;
            buy_r.found   <= 1'b0;
            sell_r.found  <= 1'b0;
            state_r       <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scanning) scan_cnt_r <= scan_cnt_r + CNT_ONE;
          if (rd_live_r) begin
            if (rd_valid_r) begin
              if (rd_data_r.id == cur_r.order_id) begin
                match_found_r <= 1'b1;
                match_idx_r   <= rd_idx_r;
                match_kind_r  <= rd_data_r.kind;
              end
              if (rd_data_r.side == lob_pkg::SIDE_BUY) begin
                if (buy_better) buy_r <= '{found: 1'b1, idx: rd_idx_r, data: rd_data_r};
              end else begin
                if (sell_better) sell_r <= '{found: 1'b1, idx: rd_idx_r, data: rd_data_r};
              end
            end else if (!free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= rd_idx_r;
            end
          end else if (!scanning) begin
            state_r <= mode_r ? S_MDEC : S_DEC;
          end
        end
        S_DEC: begin
          case (cur_r.opcode)
            lob_pkg::OP_ADD: begin
              status_r <= add_status;
              if (add_ok) begin
                valid_r[free_idx_r] <= 1'b1;
                arrival_r           <= arrival_r + 32'd1;
                count_r             <= count_r + CNT_ONE;
                new_idx_r           <= free_idx_r;
                mode_r              <= 1'b1;
                scan_cnt_r          <= '0;
                buy_r.found         <= 1'b0;
                sell_r.found        <= 1'b0;
                state_r             <= S_SCAN;
              end else begin
                state_r <= S_STAT;
              end
            end
            lob_pkg::OP_CANCEL: begin
              state_r <= S_STAT;
              if (match_found_r) begin
                valid_r[match_idx_r] <= 1'b0;
                count_r              <= count_r - CNT_ONE;
                status_r             <= lob_pkg::ST_DONE;
              end else begin
                status_r <= lob_pkg::ST_UNKNOWN;
              end
            end
            lob_pkg::OP_MODIFY: begin
              if (!match_found_r) begin
                status_r <= lob_pkg::ST_UNKNOWN;
                state_r  <= S_STAT;
              end else if (cur_r.amount == 32'd0) begin
                status_r <= lob_pkg::ST_FULL;
                state_r  <= S_STAT;
              end else begin
                // drop the old order, then rerun as an add keeping its kind
                valid_r[match_idx_r] <= 1'b0;
                count_r              <= count_r - CNT_ONE;
                cur_r.opcode         <= lob_pkg::OP_ADD;
                cur_r.order_kind     <= match_kind_r;
                scan_cnt_r           <= '0;
                match_found_r        <= 1'b0;
                free_found_r         <= 1'b0;
                buy_r.found          <= 1'b0;
                sell_r.found         <= 1'b0;
                state_r              <= S_SCAN;
              end
            end
            default: begin
              status_r <= lob_pkg::ST_DONE;
              state_r  <= S_STAT;
            end
          endcase
        end
        S_MDEC: begin
          if (buy_r.found && sell_r.found && (buy_r.data.price >= sell_r.data.price) &&
              (trades_r != lob_pkg::MAX_TRADES)) begin
            qty_r   <= (buy_r.data.remaining < sell_r.data.remaining) ?
                       buy_r.data.remaining : sell_r.data.remaining;
            state_r <= S_TRD;
          end else begin
            state_r <= S_FAK;
          end
        end
        S_TRD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_r <= '{item_kind: lob_pkg::ITEM_TRADE, buyer_id: buy_r.data.id,
                       seller_id: sell_r.data.id, buyer_price: buy_r.data.price,
                       seller_price: sell_r.data.price, filled: qty_r,
                       status: lob_pkg::ST_DONE, resting_orders: '0, last: 1'b0};
            trades_r <= trades_r + TRD_ONE;
            state_r  <= S_UPDB;
          end
        end
        S_UPDB: begin
          if (buy_left == 32'd0) begin
            valid_r[buy_r.idx] <= 1'b0;
            count_r            <= count_r - CNT_ONE;
          end
          state_r <= S_UPDS;
        end
        S_UPDS: begin
          if (sell_left == 32'd0) begin
            valid_r[sell_r.idx] <= 1'b0;
            count_r             <= count_r - CNT_ONE;
          end
          scan_cnt_r   <= '0;
          buy_r.found  <= 1'b0;
          sell_r.found <= 1'b0;
          state_r      <= S_SCAN;
        end
        S_FAK: begin
          // discard an unfilled fill-and-kill remainder
          if (cur_r.order_kind && valid_r[new_idx_r]) begin
            valid_r[new_idx_r] <= 1'b0;
            count_r            <= count_r - CNT_ONE;
          end
          state_r <= S_STAT;
        end
        S_STAT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_r <= '{item_kind: lob_pkg::ITEM_STAT, buyer_id: '0, seller_id: '0,
                       buyer_price: '0, seller_price: '0, filled: '0,
                       status: status_r, resting_orders: count_r, last: 1'b1};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.item_kind      = out_r.item_kind;
  assign out_ch.buyer_id       = out_r.buyer_id;
  assign out_ch.seller_id      = out_r.seller_id;
  assign out_ch.buyer_price    = out_r.buyer_price;
  assign out_ch.seller_price   = out_r.seller_price;
  assign out_ch.filled         = out_r.filled;
  assign out_ch.status         = out_r.status;
  assign out_ch.resting_orders = out_r.resting_orders;
  assign out_ch.last           = out_r.last;

endmodule

// ===== sv/limit_order_book_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority limit order book with a 64-slot resting store.
// ----------------------------------------------------------------------------
// Requests (add, cancel, modify) enter on in_ch and wait in a two-entry
// queue; results leave on out_ch, zero or more trade items followed by one
// status item with last set. Both channels transfer on valid and ready high.
// Every request starts with one scan of the store, one slot a cycle through
// the store's read port. A cancel, a rejected add or an unused opcode then
// ends with its status item. An accepted add rescans to match, and each fill
// adds a rescan after its trade item and book update. A modify scans once
// more before its re-add, which is then checked and matched as an add.
// Reset empties the book at once (valid bits are flip-flops) and clears the
// arrival and order counters; no clearing pass is needed.
// A stalled receiver holds the engine at the next result it must present;
// the queue keeps accepting until both its entries are taken.
// ----------------------------------------------------------------------------
module limit_order_book_matcher (
  input  logic      clk,
  input  logic      rst_n,
  lob_in_if.sink    in_ch,
  lob_out_if.source out_ch
);

  logic              q_valid;
  lob_pkg::in_item_t q_item;
  logic              q_pop;

  lob_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  lob_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== dv/lob_match_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_match_checker
// Watches both channels of the order book matcher, keeps its own copy of the
// book, works out the trades and the status item for every accepted request
// and compares each result transfer field by field with the oldest one due.
// ----------------------------------------------------------------------------
module lob_match_checker (
  input  logic clk,
  input  logic rst_n,
  lob_in_if    in_ch,
  lob_out_if   out_ch,
  output int   fail_count,
  output int   pending
);

  logic               live    [lob_pkg::CAPACITY];
  logic [31:0]        held_id [lob_pkg::CAPACITY];
  logic signed [31:0] held_px [lob_pkg::CAPACITY];
  logic [31:0]        held_qty[lob_pkg::CAPACITY];
  logic               held_sd [lob_pkg::CAPACITY];
  logic               held_fak[lob_pkg::CAPACITY];
  logic [31:0]        held_arr[lob_pkg::CAPACITY];
  logic [31:0]        arrivals;
  int                 resting;

  lob_pkg::out_item_t due_results[$];

  function automatic int slot_of(logic [31:0] id);
    for (int i = 0; i < lob_pkg::CAPACITY; i++) begin
      if (live[i] && held_id[i] == id) return i;
    end
    return -1;
  endfunction

  // Highest buy or lowest sell; equal price goes to the oldest, then lowest slot.
  function automatic int best_on(logic sd);
    int b;
    b = -1;
    for (int i = 0; i < lob_pkg::CAPACITY; i++) begin
      if (!live[i] || held_sd[i] != sd) continue;
      if (b < 0) begin
        b = i;
      end else if (sd == lob_pkg::SIDE_BUY ? held_px[i] > held_px[b] :
                   held_px[i] < held_px[b]) begin
        b = i;
      end else if (held_px[i] == held_px[b] &&
                   (arrivals - held_arr[i]) > (arrivals - held_arr[b])) begin
        b = i;
      end
    end
    return b;
  endfunction

  function automatic void drop_slot(int i);
    live[i] = 1'b0;
    if (resting > 0) resting--;
  endfunction

  function automatic logic [2:0] rest_order(logic [31:0] id, logic sd, logic fak,
                                            logic signed [31:0] px, logic [31:0] qty);
    int                 o, slot, b, s, trades;
    logic [31:0]        fill;
    lob_pkg::out_item_t t;
    if (slot_of(id) >= 0) return lob_pkg::ST_DUP;
    if (qty == 0) return lob_pkg::ST_FULL;
    if (fak) begin
      o = best_on(~sd);
      if (o < 0) return lob_pkg::ST_NOCROSS;
      if (sd == lob_pkg::SIDE_BUY ? px < held_px[o] : px > held_px[o])
        return lob_pkg::ST_NOCROSS;
    end
    slot = -1;
    for (int i = 0; i < lob_pkg::CAPACITY; i++) begin
      if (!live[i]) begin
        slot = i;
        break;
      end
    end
    if (slot < 0) return lob_pkg::ST_FULL;
    live[slot]     = 1'b1;
    held_id[slot]  = id;
    held_px[slot]  = px;
    held_qty[slot] = qty;
    held_sd[slot]  = sd;
    held_fak[slot] = fak;
    held_arr[slot] = arrivals;
    arrivals++;
    resting++;
    trades = 0;
    while (trades < lob_pkg::MAX_TRADES) begin
      b = best_on(1'b0);
      s = best_on(1'b1);
      if (b < 0 || s < 0) break;
      if (held_px[b] < held_px[s]) break;
      fill = held_qty[b] < held_qty[s] ? held_qty[b] : held_qty[s];
      t = '0;
      t.item_kind    = lob_pkg::ITEM_TRADE;
      t.buyer_id     = held_id[b];
      t.seller_id    = held_id[s];
      t.buyer_price  = held_px[b];
      t.seller_price = held_px[s];
      t.filled       = fill;
      due_results.insert(due_results.size(), t);
      trades++;
      held_qty[b] -= fill;
      held_qty[s] -= fill;
      if (held_qty[b] == 0) drop_slot(b);
      if (held_qty[s] == 0) drop_slot(s);
    end
    // discard an unfilled fill-and-kill remainder
    if (fak && live[slot]) drop_slot(slot);
    return lob_pkg::ST_DONE;
  endfunction

  function automatic void predict_request(lob_pkg::in_item_t r);
    int                 idx;
    logic [2:0]         st;
    lob_pkg::out_item_t s;
    st = lob_pkg::ST_DONE;
    if (r.opcode == lob_pkg::OP_ADD) begin
      st = rest_order(r.order_id, r.side, r.order_kind, r.limit_price, r.amount);
    end else if (r.opcode == lob_pkg::OP_CANCEL) begin
      idx = slot_of(r.order_id);
      if (idx < 0) st = lob_pkg::ST_UNKNOWN;
      else drop_slot(idx);
    end else if (r.opcode == lob_pkg::OP_MODIFY) begin
      idx = slot_of(r.order_id);
      if (idx < 0) begin
        st = lob_pkg::ST_UNKNOWN;
      end else if (r.amount == 0) begin
        st = lob_pkg::ST_FULL;
      end else begin
        drop_slot(idx);
        st = rest_order(r.order_id, r.side, held_fak[idx], r.limit_price, r.amount);
      end
    end
    s = '0;
    s.item_kind      = lob_pkg::ITEM_STAT;
    s.status         = st;
    s.resting_orders = resting[lob_pkg::CNT_W-1:0];
    s.last           = 1'b1;
    due_results.insert(due_results.size(), s);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp, act);
      fail_count++;
    end
  endfunction

  lob_pkg::in_item_t  req;
  lob_pkg::out_item_t got, exp;

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lob_pkg::CAPACITY; i++) live[i] = 1'b0;
      arrivals   = '0;
      resting    = 0;
      fail_count = 0;
      due_results.delete();
    end else begin
      // results first: a result transfer never belongs to a request of this edge
      if (out_ch.valid && out_ch.ready) begin
        got.item_kind      = out_ch.item_kind;
        got.buyer_id       = out_ch.buyer_id;
        got.seller_id      = out_ch.seller_id;
        got.buyer_price    = out_ch.buyer_price;
        got.seller_price   = out_ch.seller_price;
        got.filled         = out_ch.filled;
        got.status         = out_ch.status;
        got.resting_orders = out_ch.resting_orders;
        got.last           = out_ch.last;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, got);
          fail_count++;
        end else begin
          exp = due_results[0];
          due_results.delete(0);
          check_field("item_kind", exp.item_kind, got.item_kind);
          check_field("buyer_id", exp.buyer_id, got.buyer_id);
          check_field("seller_id", exp.seller_id, got.seller_id);
          check_field("buyer_price", exp.buyer_price, got.buyer_price);
          check_field("seller_price", exp.seller_price, got.seller_price);
          check_field("filled", exp.filled, got.filled);
          check_field("status", exp.status, got.status);
          check_field("resting_orders", exp.resting_orders, got.resting_orders);
          check_field("last", exp.last, got.last);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        req.opcode      = in_ch.opcode;
        req.order_id    = in_ch.order_id;
        req.side        = in_ch.side;
        req.order_kind  = in_ch.order_kind;
        req.limit_price = in_ch.limit_price;
        req.amount      = in_ch.amount;
        predict_request(req);
      end
    end
    pending = due_results.size();
  end

endmodule

// ===== dv/tb_limit_order_book_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_limit_order_book_matcher
// Drives order requests into the matcher with random gaps and result stalls:
// a directed opening, a full-book and trade-limit scenario, then random
// traffic around a narrow price band. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_limit_order_book_matcher;

  localparam int IDLE_LIMIT = 40000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   stall_left;
  logic calm;

  lob_in_if  in_ch ();
  lob_out_if out_ch ();

  limit_order_book_matcher dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lob_match_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side stalls in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(logic [1:0] op, logic [31:0] id, logic sd, logic fak,
                      logic signed [31:0] px, logic [31:0] qty);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.order_id    <= id;
    in_ch.side        <= sd;
    in_ch.order_kind  <= fak;
    in_ch.limit_price <= px;
    in_ch.amount      <= qty;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic random_request();
    int          pick;
    logic [1:0]  op;
    logic [31:0] id, qty;
    logic signed [31:0] px;
    pick = $urandom_range(0, 99);
    op   = pick < 55 ? lob_pkg::OP_ADD : (pick < 77 ? lob_pkg::OP_CANCEL : lob_pkg::OP_MODIFY);
    id   = $urandom_range(0, 19) == 0 ? $urandom() : $urandom_range(1, 40);
    px   = $urandom_range(0, 19) == 0 ? $signed($urandom()) : 1000 + $urandom_range(0, 16) - 8;
    pick = $urandom_range(0, 29);
    qty  = pick == 0 ? 32'd0 : (pick == 1 ? $urandom() : $urandom_range(1, 12));
    send(op, id, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, px, qty);
  endtask

  initial begin
    rst_n             = 1'b0;
    calm              = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = lob_pkg::OP_ADD;
    in_ch.order_id    = '0;
    in_ch.side        = 1'b0;
    in_ch.order_kind  = 1'b0;
    in_ch.limit_price = '0;
    in_ch.amount      = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening
    send(lob_pkg::OP_ADD, 32'h0, 1'b1, 1'b1, 32'sd5, 32'd5);        // fill-and-kill, empty book
    send(lob_pkg::OP_ADD, 32'h0, 1'b0, 1'b0, 32'h7fffffff, 32'd5);
    send(lob_pkg::OP_ADD, 32'h0, 1'b1, 1'b0, 32'sd1, 32'd1);        // duplicate id
    send(lob_pkg::OP_ADD, 32'h11, 1'b1, 1'b0, 32'sd1, 32'd0);       // zero amount
    send(lob_pkg::OP_ADD, 32'hffffffff, 1'b1, 1'b0, 32'h80000000, 32'd3); // crosses
    send(lob_pkg::OP_ADD, 32'h12, 1'b1, 1'b1, 32'h7fffffff, 32'd1); // crosses at the top
    send(lob_pkg::OP_ADD, 32'h13, 1'b0, 1'b0, -32'sd50, 32'hffffffff);
    send(lob_pkg::OP_ADD, 32'h14, 1'b1, 1'b1, 32'sd10, 32'd4);      // partial, rest dropped
    send(lob_pkg::OP_ADD, 32'h15, 1'b1, 1'b1, -32'sd60, 32'd7);     // crosses, filled in full
    send(lob_pkg::OP_CANCEL, 32'h55, 1'b0, 1'b0, 32'sd0, 32'd0);
    send(lob_pkg::OP_CANCEL, 32'h13, 1'b0, 1'b0, 32'sd0, 32'd0);
    send(lob_pkg::OP_MODIFY, 32'h56, 1'b0, 1'b0, 32'sd0, 32'd1);
    send(lob_pkg::OP_ADD, 32'h16, 1'b1, 1'b0, 32'sd20, 32'd6);
    send(lob_pkg::OP_ADD, 32'h17, 1'b0, 1'b0, 32'sd15, 32'd2);
    send(lob_pkg::OP_MODIFY, 32'h16, 1'b1, 1'b0, 32'sd20, 32'd0);   // zero amount
    send(lob_pkg::OP_MODIFY, 32'h17, 1'b0, 1'b1, 32'sd25, 32'd9);   // re-add crosses
    send(lob_pkg::OP_SPARE, 32'h16, 1'b1, 1'b1, 32'sd0, 32'd0);     // unused opcode
    send(lob_pkg::OP_MODIFY, 32'h16, 1'b0, 1'b0, 32'sd3, 32'd2);    // id already filled, unknown
    send(lob_pkg::OP_CANCEL, 32'h0, 1'b0, 1'b0, 32'sd0, 32'd0);
    send(lob_pkg::OP_CANCEL, 32'h16, 1'b0, 1'b0, 32'sd0, 32'd0);
    send(lob_pkg::OP_CANCEL, 32'h17, 1'b0, 1'b0, 32'sd0, 32'd0);

    // fill the book, overflow it, then sweep it with one buy
    for (int i = 0; i < lob_pkg::CAPACITY; i++)
      send(lob_pkg::OP_ADD, 1000 + i, 1'b1, 1'b0, 2000 + i, 32'd1);
    send(lob_pkg::OP_ADD, 32'd1999, 1'b1, 1'b0, 32'sd5000, 32'd1);
    send(lob_pkg::OP_CANCEL, 32'd1000, 1'b0, 1'b0, 32'sd0, 32'd0);
    send(lob_pkg::OP_ADD, 32'd2000, 1'b0, 1'b0, 32'sd3000, 32'd1000);
    send(lob_pkg::OP_CANCEL, 32'd2000, 1'b0, 1'b0, 32'sd0, 32'd0);

    for (int n = 0; n < 420; n++) begin
      if (n == 340) calm = 1'b1;
      random_request();
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== limit_order_book_matcher.f =====
sv/lob_pkg.sv
sv/lob_if.sv
sv/lob_front.sv
sv/lob_back.sv
sv/limit_order_book_matcher.sv
dv/lob_match_checker.sv
dv/tb_limit_order_book_matcher.sv
